// File: rtl/encoder_multiturn_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-turn tracker
// Shared property forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef ENCODER_MULTITURN_TRACKER_ASSERT_SVH
`define ENCODER_MULTITURN_TRACKER_ASSERT_SVH

// same-cycle implication
`define EMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/emt_pkg.sv
// ----------------------------------------------------------------------------
// emt_pkg
// Types, register codes and helper functions of the multi-turn tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package emt_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SHIFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_BITS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_BITS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH_ENABLE = 3'd4;

  // reset values
  localparam logic [6:0]        FIELD_BITS_RST = 7'd32;
  localparam logic [WORD_W-1:0] WRAP_LIMIT_RST = 64'h0000_0000_8000_0000;

  // flow codes
  localparam logic [1:0] FLOW_NONE  = 2'd0;
  localparam logic [1:0] FLOW_OVER  = 2'd1;
  localparam logic [1:0] FLOW_UNDER = 2'd2;

  typedef struct packed {
    logic [5:0]        field_shift;
    logic [6:0]        field_bits;
    logic [WORD_W-1:0] wrap_limit;
    logic [6:0]        abs_bits;
    logic              latch_enable;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] position_count;
    logic [WORD_W-1:0] single_turn_count;
    logic [WORD_W-1:0] absolute_part;
    logic [1:0]        flow_status;
    logic              new_latch;
    logic [WORD_W-1:0] latch_position_count;
  } result_t;

  typedef struct packed {
    logic [WORD_W-1:0] turns;
    logic [1:0]        dir;
  } turn_res_t;

  // widths above 64 behave as 64
  function automatic logic [6:0] clamp_bits(input logic [6:0] n);
    return (n > 7'd64) ? 7'd64 : n;
  endfunction

  function automatic logic [WORD_W-1:0] low_mask(input logic [6:0] n);
    logic [WORD_W-1:0] m;
    if (n >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << n[5:0]) - 64'd1;
    end
    return m;
  endfunction

  function automatic turn_res_t track_turns(input logic [WORD_W-1:0] old_cnt,
                                            input logic [WORD_W-1:0] cur_cnt,
                                            input logic [WORD_W-1:0] turns,
                                            input logic [6:0]        eff_bits,
                                            input logic [WORD_W-1:0] limit);
    turn_res_t r;
    r.turns = turns;
    r.dir   = FLOW_NONE;
    if (eff_bits >= 7'd64) begin
      // tracking off: turns forced to zero, report which way they moved
      r.turns = '0;
      if (turns != '0) begin
        r.dir = turns[WORD_W-1] ? FLOW_OVER : FLOW_UNDER;
      end
    end else if ((old_cnt > cur_cnt) && ((old_cnt - cur_cnt) > limit)) begin
      r.turns = turns + 64'd1;
      r.dir   = FLOW_OVER;
    end else if ((old_cnt < cur_cnt) && ((cur_cnt - old_cnt) > limit)) begin
      r.turns = turns - 64'd1;
      r.dir   = FLOW_UNDER;
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] compose(input logic [WORD_W-1:0] turns,
                                                input logic [WORD_W-1:0] cnt,
                                                input logic [WORD_W-1:0] offset,
                                                input logic [6:0]        eff_bits);
    logic [WORD_W-1:0] base;
    base = (eff_bits >= 7'd64) ? '0 : (turns << eff_bits[5:0]);
    return base + cnt + offset;
  endfunction

endpackage

`default_nettype wire

// File: rtl/emt_field.sv
// ----------------------------------------------------------------------------
// emt_field
// Cuts the count field out of a raw encoder word by shift and mask.
// ----------------------------------------------------------------------------
`default_nettype none

module emt_field #(
  parameter int unsigned RAW_WIDTH = 64
) (
  input  wire logic [RAW_WIDTH-1:0]      word,
  input  wire logic [5:0]                field_shift,
  input  wire logic [6:0]                field_bits,
  output logic      [emt_pkg::WORD_W-1:0] count
);

  logic [emt_pkg::WORD_W-1:0] word_ext;

  assign word_ext = emt_pkg::WORD_W'(word);
  assign count    = (word_ext >> field_shift)
                    & emt_pkg::low_mask(emt_pkg::clamp_bits(field_bits));

endmodule

`default_nettype wire

// File: rtl/emt_core.sv
// ----------------------------------------------------------------------------
// emt_core
// Turn tracking state and the single-pass position and latch computation.
// ----------------------------------------------------------------------------
`default_nettype none

module emt_core #(
  parameter int unsigned RAW_WIDTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire emt_pkg::cfg_t              cfg,
  input  wire logic                       mode,
  input  wire logic [RAW_WIDTH-1:0]       raw_word,
  input  wire logic                       latch_status,
  input  wire logic [RAW_WIDTH-1:0]       latch_word,
  input  wire logic [emt_pkg::WORD_W-1:0] preset_count,
  output emt_pkg::result_t                res
);

  `include "encoder_multiturn_tracker_assert.svh"

  logic [emt_pkg::WORD_W-1:0] previous_count, previous_count_next;
  logic [emt_pkg::WORD_W-1:0] turn_counter, turn_counter_next;
  logic [emt_pkg::WORD_W-1:0] position_offset, position_offset_next;
  logic                       previous_latch_status, previous_latch_status_next;
  logic [emt_pkg::WORD_W-1:0] latched_position, latched_position_next;

  logic [emt_pkg::WORD_W-1:0] count;
  logic [emt_pkg::WORD_W-1:0] lcount;
  logic [6:0]                 eff_bits;

  emt_field #(.RAW_WIDTH(RAW_WIDTH)) u_field_raw (
    .word        (raw_word),
    .field_shift (cfg.field_shift),
    .field_bits  (cfg.field_bits),
    .count       (count)
  );

  emt_field #(.RAW_WIDTH(RAW_WIDTH)) u_field_latch (
    .word        (latch_word),
    .field_shift (cfg.field_shift),
    .field_bits  (cfg.field_bits),
    .count       (lcount)
  );

  assign eff_bits = emt_pkg::clamp_bits(cfg.field_bits);

  always_comb begin
    emt_pkg::turn_res_t tr;
    emt_pkg::turn_res_t ltr;
    tr  = emt_pkg::track_turns(previous_count, count, turn_counter, eff_bits,
                               cfg.wrap_limit);
    // latch judged against the turns held before this sample
    ltr = emt_pkg::track_turns(previous_count, lcount, turn_counter, eff_bits,
                               cfg.wrap_limit);

    previous_count_next        = previous_count;
    turn_counter_next          = turn_counter;
    position_offset_next       = position_offset;
    previous_latch_status_next = previous_latch_status;
    latched_position_next      = latched_position;
    res.position_count         = preset_count;
    res.flow_status            = emt_pkg::FLOW_NONE;
    res.new_latch              = 1'b0;

    if (mode) begin
      turn_counter_next    = '0;
      position_offset_next = preset_count - previous_count;
    end else begin
      turn_counter_next   = tr.turns;
      previous_count_next = count;
      res.position_count  = emt_pkg::compose(tr.turns, count, position_offset, eff_bits);
      res.flow_status     = tr.dir;
      if (cfg.latch_enable) begin
        if (latch_status && !previous_latch_status) begin
          latched_position_next = emt_pkg::compose(ltr.turns, lcount, position_offset,
                                                   eff_bits);
          res.new_latch         = 1'b1;
        end
        previous_latch_status_next = latch_status;
      end
    end

    res.single_turn_count    = previous_count_next;
    res.absolute_part        = previous_count_next
                               & emt_pkg::low_mask(emt_pkg::clamp_bits(cfg.abs_bits));
    res.latch_position_count = latched_position_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_count        <= '0;
      turn_counter          <= '0;
      position_offset       <= '0;
      previous_latch_status <= 1'b0;
      latched_position      <= '0;
    end else if (step) begin
      previous_count        <= previous_count_next;
      turn_counter          <= turn_counter_next;
      position_offset       <= position_offset_next;
      previous_latch_status <= previous_latch_status_next;
      latched_position      <= latched_position_next;
    end
  end

  `EMT_ASSERT_NXT(a_preset_clears_turns, step && mode, turn_counter == '0, "preset left turns")
  `EMT_ASSERT_NXT(a_untracked_no_turns, step && (eff_bits >= 7'd64), turn_counter == '0, "turns kept with tracking off")
  `EMT_ASSERT_NXT(a_latch_off_holds, step && !cfg.latch_enable, $stable(latched_position) && $stable(previous_latch_status), "latch state moved while disabled")
  `EMT_ASSERT_NXT(a_sample_keeps_offset, step && !mode, $stable(position_offset), "offset moved on a sample")

endmodule

`default_nettype wire

// File: rtl/encoder_multiturn_tracker.sv
// ----------------------------------------------------------------------------
// encoder_multiturn_tracker
// Extends a single-turn encoder count into a multi-turn position.
// ----------------------------------------------------------------------------
// Takes one sample request per clock while in_stall is low and returns one
// result per request. The result is presented on the outputs from the result
// register, which holds it while the output is stalled. Requests pass an
// input register, one combinational stage that extracts the count, tracks
// turns and composes the position against the held state, and a result
// register; the tracking state updates as the request moves into the result
// register, so a new sample can follow every cycle while not stalled.
// Registers may be written only while no request is in flight.
`default_nettype none

module encoder_multiturn_tracker #(
  parameter int unsigned RAW_WIDTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration
  input  wire logic                        cfg_write,
  input  wire logic [emt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [emt_pkg::WORD_W-1:0]  cfg_data,
  // sample channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        mode,
  input  wire logic [RAW_WIDTH-1:0]        raw_word,
  input  wire logic                        latch_status,
  input  wire logic [RAW_WIDTH-1:0]        latch_word,
  input  wire logic signed [emt_pkg::WORD_W-1:0] preset_count,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [emt_pkg::WORD_W-1:0] position_count,
  output logic [emt_pkg::WORD_W-1:0]       single_turn_count,
  output logic [emt_pkg::WORD_W-1:0]       absolute_part,
  output logic [1:0]                       flow_status,
  output logic                             new_latch,
  output logic signed [emt_pkg::WORD_W-1:0] latch_position_count
);

  `include "encoder_multiturn_tracker_assert.svh"

  emt_pkg::cfg_t cfg;

  logic                       s1_valid;
  logic                       s1_mode;
  logic [RAW_WIDTH-1:0]       s1_raw_word;
  logic                       s1_latch_status;
  logic [RAW_WIDTH-1:0]       s1_latch_word;
  logic [emt_pkg::WORD_W-1:0] s1_preset_count;

  logic                       advance;
  logic                       in_take;
  emt_pkg::result_t           core_res;
  emt_pkg::result_t           out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.field_shift  <= '0;
      cfg.field_bits   <= emt_pkg::FIELD_BITS_RST;
      cfg.wrap_limit   <= emt_pkg::WRAP_LIMIT_RST;
      cfg.abs_bits     <= '0;
      cfg.latch_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        emt_pkg::CFG_FIELD_SHIFT:  cfg.field_shift  <= cfg_data[5:0];
        emt_pkg::CFG_FIELD_BITS:   cfg.field_bits   <= cfg_data[6:0];
        emt_pkg::CFG_WRAP_LIMIT:   cfg.wrap_limit   <= cfg_data;
        emt_pkg::CFG_ABS_BITS:     cfg.abs_bits     <= cfg_data[6:0];
        emt_pkg::CFG_LATCH_ENABLE: cfg.latch_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // result register free, or being emptied this cycle
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance || !s1_valid) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode         <= mode;
      s1_raw_word     <= raw_word;
      s1_latch_status <= latch_status;
      s1_latch_word   <= latch_word;
      s1_preset_count <= emt_pkg::WORD_W'(preset_count);
    end
  end

  emt_core #(.RAW_WIDTH(RAW_WIDTH)) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_valid && advance),
    .cfg          (cfg),
    .mode         (s1_mode),
    .raw_word     (s1_raw_word),
    .latch_status (s1_latch_status),
    .latch_word   (s1_latch_word),
    .preset_count (s1_preset_count),
    .res          (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_res <= core_res;
    end
  end

  assign position_count       = $signed(out_res.position_count);
  assign single_turn_count    = out_res.single_turn_count;
  assign absolute_part        = out_res.absolute_part;
  assign flow_status          = out_res.flow_status;
  assign new_latch            = out_res.new_latch;
  assign latch_position_count = $signed(out_res.latch_position_count);

  `EMT_ASSERT_IMP(a_stall_only_when_full, in_stall, s1_valid && out_valid && out_stall, "stall without a full pipe")
  `EMT_ASSERT_NXT(a_stage_moves_on, s1_valid && advance, out_valid, "request lost between stages")
  `EMT_ASSERT_NXT(a_take_fills_stage, in_take, s1_valid, "accepted request not held")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-turn encoder tracker testbench
// Feeds encoder sample and preset requests through the tracker under random
// idling on both channels and checks every result against a typed result or
// a local model of the turn counting, latch capture and preset behaviour.
// ----------------------------------------------------------------------------

module tb;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    logic [emt_pkg::CFG_IDX_W-1:0] reg_idx;
    logic                          is_preset;
    logic [63:0]                   raw;
    logic                          ls;
    logic [63:0]                   lw;
    logic [63:0]                   preset;
    bit                            typed;
    emt_pkg::result_t              want;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [emt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]                   cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          mode = 1'b0;
  logic [63:0]                   raw_word = '0;
  logic                          latch_status = 1'b0;
  logic [63:0]                   latch_word = '0;
  logic signed [63:0]            preset_count = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [63:0]            position_count;
  logic [63:0]                   single_turn_count;
  logic [63:0]                   absolute_part;
  logic [1:0]                    flow_status;
  logic                          new_latch;
  logic signed [63:0]            latch_position_count;

  encoder_multiturn_tracker dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .raw_word(raw_word),
    .latch_status(latch_status), .latch_word(latch_word), .preset_count(preset_count),
    .out_valid(out_valid), .out_stall(out_stall), .position_count(position_count),
    .single_turn_count(single_turn_count), .absolute_part(absolute_part),
    .flow_status(flow_status), .new_latch(new_latch),
    .latch_position_count(latch_position_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // tracker model: registers and state, at their reset values
  logic [5:0]  trk_shift = '0;
  logic [6:0]  trk_bits = emt_pkg::FIELD_BITS_RST;
  logic [63:0] trk_wrap = emt_pkg::WRAP_LIMIT_RST;
  logic [6:0]  trk_abs = '0;
  logic        trk_latch_en = 1'b0;
  logic [63:0] trk_prev_cnt = '0;
  logic [63:0] trk_turns = '0;
  logic [63:0] trk_offset = '0;
  logic        trk_prev_ls = 1'b0;
  logic [63:0] trk_latch_pos = '0;

  emt_pkg::result_t position_q[$];
  stim_row_t        directed_rows[$];
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      mismatches = 0;
  int unsigned      results_seen = 0;
  int unsigned      hold_left = 0;
  bit               hold_request = 1'b0;
  emt_pkg::result_t got, want;

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] ones_below(input logic [6:0] n);
    if (n >= 7'd64) return '1;
    return (64'd1 << n[5:0]) - 64'd1;
  endfunction

  function automatic logic [6:0] count_width();
    return (trk_bits > 7'd64) ? 7'd64 : trk_bits;
  endfunction

  function automatic logic [63:0] cut_count(input logic [63:0] w);
    return (w >> trk_shift) & ones_below(count_width());
  endfunction

  function automatic logic [63:0] step_turns(input logic [63:0] old_cnt, cur_cnt, t,
                                             output logic [1:0] dir);
    dir = emt_pkg::FLOW_NONE;
    if (count_width() >= 7'd64) begin
      // tracking off: turns dropped, direction tells which way they went
      if (t != '0) dir = t[63] ? emt_pkg::FLOW_OVER : emt_pkg::FLOW_UNDER;
      return '0;
    end
    if (old_cnt > cur_cnt && old_cnt - cur_cnt > trk_wrap) begin
      dir = emt_pkg::FLOW_OVER;
      return t + 64'd1;
    end
    if (old_cnt < cur_cnt && cur_cnt - old_cnt > trk_wrap) begin
      dir = emt_pkg::FLOW_UNDER;
      return t - 64'd1;
    end
    return t;
  endfunction

  function automatic logic [63:0] place_position(input logic [63:0] t, cnt);
    logic [63:0] base;
    base = (count_width() >= 7'd64) ? 64'd0 : (t << count_width());
    return base + cnt + trk_offset;
  endfunction

  function automatic emt_pkg::result_t result_of(input logic [63:0] pos, single, absp,
                                                 input logic [1:0] flow, input logic nl,
                                                 input logic [63:0] lpos);
    emt_pkg::result_t r;
    r.position_count       = pos;
    r.single_turn_count    = single;
    r.absolute_part        = absp;
    r.flow_status          = flow;
    r.new_latch            = nl;
    r.latch_position_count = lpos;
    return r;
  endfunction

  function automatic emt_pkg::result_t track_sample(input logic is_preset,
                                                    input logic [63:0] rw,
                                                    input logic ls, input logic [63:0] lw,
                                                    input logic [63:0] pc);
    logic [63:0] old_cnt, old_turns, cnt, lcnt, lturns, pos;
    logic [1:0]  flow, lflow;
    logic        nl;
    logic [6:0]  ab;
    flow = emt_pkg::FLOW_NONE;
    nl = 1'b0;
    if (is_preset) begin
      trk_turns = '0;
      trk_offset = pc - trk_prev_cnt;
      pos = pc;
    end else begin
      old_cnt = trk_prev_cnt;
      old_turns = trk_turns;
      cnt = cut_count(rw);
      trk_turns = step_turns(old_cnt, cnt, old_turns, flow);
      trk_prev_cnt = cnt;
      pos = place_position(trk_turns, cnt);
      if (trk_latch_en) begin
        if (ls && !trk_prev_ls) begin
          // latch may predate a wrap in this sample: judge it against the old turns
          lcnt = cut_count(lw);
          lturns = step_turns(old_cnt, lcnt, old_turns, lflow);
          trk_latch_pos = place_position(lturns, lcnt);
          nl = 1'b1;
        end
        trk_prev_ls = ls;
      end
    end
    ab = (trk_abs > 7'd64) ? 7'd64 : trk_abs;
    return result_of(pos, trk_prev_cnt, (ab == 7'd0) ? 64'd0 : (trk_prev_cnt & ones_below(ab)),
                     flow, nl, trk_latch_pos);
  endfunction

  task automatic offer_sample(input logic is_preset, input logic [63:0] rw, input logic ls,
                              input logic [63:0] lw, input logic [63:0] pc,
                              input bit typed, input emt_pkg::result_t typed_res);
    emt_pkg::result_t predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    mode         <= is_preset;
    raw_word     <= rw;
    latch_status <= ls;
    latch_word   <= lw;
    preset_count <= pc;
    do @(posedge clk); while (in_stall);
    predicted = track_sample(is_preset, rw, ls, lw, pc);
    position_q.push_back(typed ? typed_res : predicted);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (position_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [emt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      emt_pkg::CFG_FIELD_SHIFT:  trk_shift = val[5:0];
      emt_pkg::CFG_FIELD_BITS:   trk_bits = val[6:0];
      emt_pkg::CFG_WRAP_LIMIT:   trk_wrap = val;
      emt_pkg::CFG_ABS_BITS:     trk_abs = val[6:0];
      emt_pkg::CFG_LATCH_ENABLE: trk_latch_en = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic void add_sample(input logic is_preset, input logic [63:0] rw,
                                     input logic ls, input logic [63:0] lw,
                                     input logic [63:0] pc);
    directed_rows.push_back('{ROW_SAMPLE, '0, is_preset, rw, ls, lw, pc, 1'b0, '0});
  endfunction

  function automatic void add_typed(input logic is_preset, input logic [63:0] rw,
                                    input logic ls, input logic [63:0] lw,
                                    input logic [63:0] pc, input emt_pkg::result_t r);
    directed_rows.push_back('{ROW_SAMPLE, '0, is_preset, rw, ls, lw, pc, 1'b1, r});
  endfunction

  function automatic void add_reg(input logic [emt_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [63:0] val);
    directed_rows.push_back('{ROW_REG, idx, 1'b0, val, 1'b0, '0, '0, 1'b0, '0});
  endfunction

  // result side: random stall, long hold-off on request, in-order check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = result_of(position_count, single_turn_count, absolute_part, flow_status,
                      new_latch, latch_position_count);
      if (position_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no request outstanding: pos %h", results_seen,
                   got.position_count);
      end else begin
        want = position_q.pop_front();
        if (got.position_count !== want.position_count ||
            got.single_turn_count !== want.single_turn_count ||
            got.absolute_part !== want.absolute_part ||
            got.flow_status !== want.flow_status ||
            got.new_latch !== want.new_latch ||
            got.latch_position_count !== want.latch_position_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d wrong: pos/single/abs/flow/latch/latch pos", results_seen);
            $display("  exp %h %h %h %0d %0d %h", want.position_count, want.single_turn_count,
                     want.absolute_part, want.flow_status, want.new_latch,
                     want.latch_position_count);
            $display("  got %h %h %h %0d %0d %h", got.position_count, got.single_turn_count,
                     got.absolute_part, got.flow_status, got.new_latch,
                     got.latch_position_count);
          end
        end
      end
      results_seen++;
    end
    if (hold_request) begin
      hold_left = 150;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int unsigned width_plan[9] = '{12, 1, 32, 64, 0, 127, 8, 63, 20};
    logic [6:0]  bits, eff;
    logic [5:0]  shift;
    logic [63:0] wrap, cmask, enc_pos, prior, step, rw, lw, junk;
    logic [6:0]  absb;
    logic        len, ls_level;
    int unsigned roll;

    // after reset: sample at zero, full-scale rise, presets at the extremes
    add_typed(1'b0, 64'h0, 1'b0, 64'h0, 64'h0,
              result_of(64'h0, 64'h0, 64'h0, emt_pkg::FLOW_NONE, 1'b0, 64'h0));
    add_typed(1'b0, '1, 1'b1, '1, 64'h0,
              result_of('1, 64'hFFFF_FFFF, 64'h0, emt_pkg::FLOW_UNDER, 1'b0, 64'h0));
    add_reg(emt_pkg::CFG_FIELD_BITS, 64'd64);
    // tracking switched off with negative turns pending
    add_typed(1'b0, '1, 1'b0, 64'h0, 64'h0,
              result_of('1, '1, 64'h0, emt_pkg::FLOW_OVER, 1'b0, 64'h0));
    add_reg(emt_pkg::CFG_FIELD_BITS, 64'd32);
    add_typed(1'b1, 64'h0, 1'b0, 64'h0, 64'h8000_0000_0000_0000,
              result_of(64'h8000_0000_0000_0000, '1, 64'h0, emt_pkg::FLOW_NONE, 1'b0,
                        64'h0));
    add_typed(1'b1, '1, 1'b1, '1, 64'h7FFF_FFFF_FFFF_FFFF,
              result_of(64'h7FFF_FFFF_FFFF_FFFF, '1, 64'h0, emt_pkg::FLOW_NONE, 1'b0,
                        64'h0));
    add_sample(1'b0, 64'h0000_0000_4000_0000, 1'b0, 64'h0, 64'h0);
    add_typed(1'b1, 64'h0, 1'b0, 64'h0, 64'h0,
              result_of(64'h0, 64'h4000_0000, 64'h0, emt_pkg::FLOW_NONE, 1'b0, 64'h0));
    // absolute part wider than the field, latch on
    add_reg(emt_pkg::CFG_ABS_BITS, 64'd127);
    add_reg(emt_pkg::CFG_LATCH_ENABLE, 64'd1);
    add_sample(1'b0, 64'hDEAD_BEEF_1234_5678, 1'b0, 64'h0, 64'h0);
    add_sample(1'b0, 64'hDEAD_BEEF_1234_5600, 1'b1, 64'hFFFF_FFFF_0000_0010, 64'h0);
    add_sample(1'b0, 64'h0000_0000_1234_5000, 1'b1, 64'h0, 64'h0);
    add_sample(1'b0, 64'h0000_0000_FFFF_FF00, 1'b0, 64'h0, 64'h0);
    // wrap after the latch fired: latched word still on the old turn
    add_sample(1'b0, 64'h0000_0000_0000_0100, 1'b1, 64'h0000_0000_FFFF_FFF0, 64'h0);
    add_reg(emt_pkg::CFG_FIELD_BITS, 64'd64);
    add_sample(1'b0, '1, 1'b0, '1, 64'h0);
    add_reg(emt_pkg::CFG_FIELD_BITS, 64'd0);
    add_sample(1'b0, 64'h5A5A_A5A5_0F0F_F0F0, 1'b1, 64'h1, 64'h0);
    add_reg(emt_pkg::CFG_FIELD_BITS, 64'd127);
    add_reg(emt_pkg::CFG_FIELD_SHIFT, 64'd63);
    add_sample(1'b0, 64'h8000_0000_0000_0000, 1'b0, '1, 64'h0);
    add_reg(emt_pkg::CFG_FIELD_SHIFT, 64'd0);
    add_reg(emt_pkg::CFG_FIELD_BITS, 64'd32);
    add_reg(emt_pkg::CFG_WRAP_LIMIT, 64'd0);
    add_sample(1'b0, 64'd5, 1'b0, 64'h0, 64'h0);
    add_sample(1'b0, 64'd4, 1'b0, 64'h0, 64'h0);
    add_sample(1'b0, 64'd6, 1'b0, 64'h0, 64'h0);
    add_reg(emt_pkg::CFG_WRAP_LIMIT, '1);
    add_sample(1'b0, 64'hFFFF_FFFF, 1'b0, 64'h0, 64'h0);
    add_sample(1'b0, 64'h0, 1'b0, 64'h0, 64'h0);
    // latch edge ignored while disabled
    add_reg(emt_pkg::CFG_ABS_BITS, 64'd0);
    add_reg(emt_pkg::CFG_LATCH_ENABLE, 64'd0);
    add_sample(1'b0, 64'h1234, 1'b0, 64'h0, 64'h0);
    add_sample(1'b0, 64'h1235, 1'b1, 64'h99, 64'h0);
    add_sample(1'b1, 64'h0, 1'b0, 64'h0, 64'h0123_4567_89AB_CDEF);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 30;
    recv_idle_pct = 66;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].raw);
      end else begin
        offer_sample(directed_rows[i].is_preset, directed_rows[i].raw, directed_rows[i].ls,
                     directed_rows[i].lw, directed_rows[i].preset, directed_rows[i].typed,
                     directed_rows[i].want);
      end
    end

    for (int phase = 0; phase < 9; phase++) begin
      case (phase / 3)
        0:       begin send_idle_pct = 30; recv_idle_pct = 66; end
        1:       begin send_idle_pct = 66; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      settle();

      bits = 7'(width_plan[phase]);
      eff = (bits > 7'd64) ? 7'd64 : bits;
      if (phase == 1)
        shift = 6'd63;
      else if (phase == 4)
        shift = 6'd0;
      else if (eff < 7'd64 && $urandom_range(0, 3) != 0)
        shift = 6'($urandom_range(0, (64 - eff > 63) ? 63 : 64 - eff));
      else
        shift = 6'($urandom_range(0, 63));
      if (phase == 2)
        wrap = 64'd0;
      else if (phase == 7)
        wrap = '1;
      else if (eff > 7'd0 && eff < 7'd64 && $urandom_range(0, 9) < 7)
        wrap = 64'd1 << (eff - 7'd1);
      else
        wrap = rand_word() >> $urandom_range(0, 63);
      absb = (phase == 0) ? 7'd0 : (phase == 5) ? 7'd127 : 7'($urandom_range(0, 70));
      len = (phase == 0) ? 1'b0 : ($urandom_range(0, 4) != 0);

      // upper data bits beyond each register are don't-care
      junk = rand_word();
      write_reg(emt_pkg::CFG_FIELD_SHIFT, {junk[63:6], shift});
      write_reg(emt_pkg::CFG_FIELD_BITS, {junk[63:7], bits});
      write_reg(emt_pkg::CFG_WRAP_LIMIT, wrap);
      write_reg(emt_pkg::CFG_ABS_BITS, {junk[57:1], absb});
      write_reg(emt_pkg::CFG_LATCH_ENABLE, {junk[62:0], len});

      if (phase % 3 == 0) hold_request = 1'b1;

      cmask = ones_below(eff);
      enc_pos = rand_word();
      ls_level = 1'b0;
      for (int n = 0; n < 205; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          offer_sample(1'b1, rand_word(), 1'($urandom_range(0, 1)), rand_word(), rand_word(),
                       1'b0, '0);
        end else if (roll < 14) begin
          offer_sample(1'b0, rand_word(), 1'($urandom_range(0, 1)), rand_word(), rand_word(),
                       1'b0, '0);
        end else begin
          // encoder moving in steps below a quarter of the count field range, occasional big jumps
          prior = enc_pos;
          if ($urandom_range(0, 9) == 0)
            step = rand_word();
          else
            step = rand_word() & ones_below((eff > 7'd2) ? eff - 7'd2 : 7'd0);
          enc_pos = $urandom_range(0, 1) ? enc_pos + step : enc_pos - step;
          if ($urandom_range(0, 3) == 0) ls_level = !ls_level;
          rw = (rand_word() & ~(cmask << shift)) | ((enc_pos & cmask) << shift);
          lw = (rand_word() & ~(cmask << shift)) |
               ((($urandom_range(0, 1) ? prior : enc_pos) & cmask) << shift);
          offer_sample(1'b0, rw, ls_level, lw, rand_word(), 1'b0, '0);
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
